// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/dbyp_pkg.sv
`default_nettype none

package dbyp_pkg;

	localparam int NUM_LANES  = 4;
	localparam int DEPTH_W    = 24;
	localparam int PROD_W     = 2 * DEPTH_W;
	localparam int FRAC_W     = 32;
	localparam int LUMA_W     = 8;
	localparam int SUM_W      = FRAC_W + 2;
	localparam int CNT_W      = 3;

	localparam logic [DEPTH_W-1:0] SCALE_RESET   = 24'd2080768;
	localparam logic [LUMA_W-1:0]  LUMA_INVALID  = 8'd255;
	localparam logic [LUMA_W-1:0]  LUMA_MAX      = 8'd254;
	localparam logic [15:0]        INT_LIMIT     = 16'd254;

	// Per-lane result handed to the merge stage.
	typedef struct packed {
		logic                ok;
		logic [LUMA_W-1:0]   luma;
		logic [FRAC_W-1:0]   frac;
	} lane_out_t;

	// Stage advance enables of the pipeline.
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
	} pipe_ctl_t;

	// Mean fraction times 255, truncated; 0 for an empty class.
	// Counts 1, 2 and 4 divide by a shift; a count of 3 uses 255 / 3 = 85.
	function automatic logic [LUMA_W-1:0] class_chroma(input logic [SUM_W-1:0] sum,
			input logic [CNT_W-1:0] cnt);
		logic [SUM_W+7:0] x255;
		logic [SUM_W+6:0] x85;
		logic [LUMA_W-1:0] res;
		x255 = {sum, 8'd0} - {8'd0, sum};
		x85  = {1'b0, sum, 6'd0} + {3'b0, sum, 4'd0} + {5'b0, sum, 2'd0} + {7'b0, sum};
		case (cnt)
			3'd1:    res = x255[39:32];
			3'd2:    res = x255[40:33];
			3'd3:    res = x85[39:32];
			3'd4:    res = x255[41:34];
			default: res = '0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

// File: hdl/dbyp_lane.sv
`default_nettype none
`include "assert_macros.svh"

module dbyp_lane (
	input  wire                                clk,
	input  wire                                arst_n,
	input  dbyp_pkg::pipe_ctl_t                ctl,
	input  wire  [dbyp_pkg::DEPTH_W-1:0]       depth,
	input  wire                                invalid,
	input  wire  [dbyp_pkg::DEPTH_W-1:0]       scale,
	output dbyp_pkg::lane_out_t                lane_out
);
	import dbyp_pkg::*;

	logic [PROD_W-1:0] prod_s1;
	logic              ok_s1;
	lane_out_t         res_s2;
	lane_out_t         res_c;

	// Stage 1: exact Q16.32 product of depth and scale.
	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			prod_s1 <= {{(PROD_W-DEPTH_W){1'b0}}, depth} * {{(PROD_W-DEPTH_W){1'b0}}, scale};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_s1 <= 1'b0;
		end else if (ctl.en1) begin
			ok_s1 <= !invalid;
		end
	end

	// Split into luma and fraction, saturating just below 255; an invalid lane gets luma 255.
	always_comb begin
		res_c.ok = ok_s1;
		if (!ok_s1) begin
			res_c.luma = LUMA_INVALID;
			res_c.frac = '0;
		end else if (prod_s1[PROD_W-1:FRAC_W] > INT_LIMIT) begin
			res_c.luma = LUMA_MAX;
			res_c.frac = '1;
		end else begin
			res_c.luma = prod_s1[FRAC_W+LUMA_W-1:FRAC_W];
			res_c.frac = prod_s1[FRAC_W-1:0];
		end
	end

	// Stage 2: lane result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (ctl.en2) begin
			res_s2 <= res_c;
		end
	end

	assign lane_out = res_s2;

	`ASSERT_IMPLIES(a_valid_luma_range, clk, arst_n, res_s2.ok, res_s2.luma != LUMA_INVALID,
		"valid lane produced the invalid luma code")
	`ASSERT_IMPLIES(a_saturated_frac, clk, arst_n, res_s2.ok && res_s2.luma == LUMA_MAX
		&& $past(prod_s1[PROD_W-1:FRAC_W]) > INT_LIMIT && $past(ctl.en2),
		res_s2.frac == '1, "saturated lane lost its all-ones fraction")

endmodule

`default_nettype wire

// File: hdl/dbyp_merge.sv
`default_nettype none
`include "assert_macros.svh"

module dbyp_merge (
	input  wire                                              clk,
	input  wire                                              arst_n,
	input  dbyp_pkg::pipe_ctl_t                              ctl,
	input  dbyp_pkg::lane_out_t [dbyp_pkg::NUM_LANES-1:0]    lanes,
	output logic [dbyp_pkg::NUM_LANES-1:0][dbyp_pkg::LUMA_W-1:0] luma_s3,
	output logic [dbyp_pkg::SUM_W-1:0]                       u_sum_s3,
	output logic [dbyp_pkg::CNT_W-1:0]                       u_cnt_s3,
	output logic [dbyp_pkg::SUM_W-1:0]                       v_sum_s3,
	output logic [dbyp_pkg::CNT_W-1:0]                       v_cnt_s3
);
	import dbyp_pkg::*;

	logic [LUMA_W-1:0] u_luma;
	logic [SUM_W-1:0]  u_sum_c;
	logic [SUM_W-1:0]  v_sum_c;
	logic [CNT_W-1:0]  u_cnt_c;
	logic [CNT_W-1:0]  v_cnt_c;

	// The first valid lane fixes the luma of class u.
	always_comb begin
		u_luma = lanes[NUM_LANES-1].luma;
		for (int i = NUM_LANES - 1; i >= 0; i--) begin
			if (lanes[i].ok) begin
				u_luma = lanes[i].luma;
			end
		end
	end

	// Sort valid lanes into the two classes and accumulate.
	always_comb begin
		u_sum_c = '0;
		v_sum_c = '0;
		u_cnt_c = '0;
		v_cnt_c = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			if (lanes[i].ok) begin
				if (lanes[i].luma == u_luma) begin
					u_sum_c = u_sum_c + {2'b00, lanes[i].frac};
					u_cnt_c = u_cnt_c + 3'd1;
				end else begin
					v_sum_c = v_sum_c + {2'b00, lanes[i].frac};
					v_cnt_c = v_cnt_c + 3'd1;
				end
			end
		end
	end

	// Stage 3: class totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_cnt_s3 <= '0;
			v_cnt_s3 <= '0;
		end else if (ctl.en3) begin
			u_cnt_s3 <= u_cnt_c;
			v_cnt_s3 <= v_cnt_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en3) begin
			u_sum_s3 <= u_sum_c;
			v_sum_s3 <= v_sum_c;
			for (int i = 0; i < NUM_LANES; i++) begin
				luma_s3[i] <= lanes[i].luma;
			end
		end
	end

	`ASSERT_ALWAYS(a_count_total, clk, arst_n, ({1'b0, u_cnt_s3} + {1'b0, v_cnt_s3}) <= 4'd4,
		"class counts exceed the lane count")
	`ASSERT_IMPLIES(a_v_needs_u, clk, arst_n, v_cnt_s3 != '0, u_cnt_s3 != '0,
		"class v filled while class u is empty")

endmodule

`default_nettype wire

// File: hdl/depth_block_to_yuv_pack.sv
// An accepted input transaction passes through the stage 1 to stage 4 registers,
// and m_axis_tvalid is the valid bit of stage 4.
// Throughput: one 2x2 block per cycle unless the output stalls; four multiplier
// lanes, a merge stage and a chroma stage form a four-stage pipeline, each stage
// stalling on its own. Reset (arst_n low, asynchronous) empties the pipeline and
// loads depth_scale with its default of 31.75 in Q8.16; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module depth_block_to_yuv_pack (
	input  wire         clk,
	input  wire         arst_n,
	// Scale register write channel.
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [23:0] cfg_data,
	// Input blocks.
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// depth_top_left, depth_top_right, depth_bottom_left, depth_bottom_right
	input  wire  [95:0] s_axis_tdata,
	// invalid_top_left, invalid_top_right, invalid_bottom_left, invalid_bottom_right
	input  wire  [3:0]  s_axis_tuser,
	// Packed results.
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
	// chroma_u, chroma_v
	output logic [47:0] m_axis_tdata
);
	import dbyp_pkg::*;

	logic [DEPTH_W-1:0]                    depth_scale_q;
	logic                                  v1_q, v2_q, v3_q, v4_q;
	pipe_ctl_t                             ctl;
	lane_out_t [NUM_LANES-1:0]             lanes;
	logic [NUM_LANES-1:0][LUMA_W-1:0]      luma_s3;
	logic [SUM_W-1:0]                      u_sum_s3, v_sum_s3;
	logic [CNT_W-1:0]                      u_cnt_s3, v_cnt_s3;
	logic [NUM_LANES-1:0][LUMA_W-1:0]      luma_s4;
	logic [LUMA_W-1:0]                     chroma_u_s4, chroma_v_s4;

	// Scale register; the user writes only while the pipeline is idle, not enforced.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_scale_q <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			depth_scale_q <= cfg_data;
		end
	end

	// A stage advances when it is empty or the next stage advances.
	always_comb begin
		ctl.en4 = !v4_q || m_axis_tready;
		ctl.en3 = !v3_q || ctl.en4;
		ctl.en2 = !v2_q || ctl.en3;
		ctl.en1 = !v1_q || ctl.en2;
	end

	assign s_axis_tready = ctl.en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (ctl.en1) v1_q <= s_axis_tvalid;
			if (ctl.en2) v2_q <= v1_q;
			if (ctl.en3) v3_q <= v2_q;
			if (ctl.en4) v4_q <= v3_q;
		end
	end

	// One multiply lane per sample.
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		dbyp_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.depth    (s_axis_tdata[g*DEPTH_W +: DEPTH_W]),
			.invalid  (s_axis_tuser[g]),
			.scale    (depth_scale_q),
			.lane_out (lanes[g])
		);
	end

	dbyp_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.lanes    (lanes),
		.luma_s3  (luma_s3),
		.u_sum_s3 (u_sum_s3),
		.u_cnt_s3 (u_cnt_s3),
		.v_sum_s3 (v_sum_s3),
		.v_cnt_s3 (v_cnt_s3)
	);

	// Stage 4: chroma means and the output register.
	always_ff @(posedge clk) begin
		if (ctl.en4) begin
			luma_s4     <= luma_s3;
			chroma_u_s4 <= class_chroma(u_sum_s3, u_cnt_s3);
			chroma_v_s4 <= class_chroma(v_sum_s3, v_cnt_s3);
		end
	end

	assign m_axis_tvalid = v4_q;
	assign m_axis_tdata  = {chroma_v_s4, chroma_u_s4, luma_s4[3], luma_s4[2],
		luma_s4[1], luma_s4[0]};

	`ASSERT_IMPLIES(a_stall_means_full, clk, arst_n, !s_axis_tready,
		v1_q && v2_q && v3_q && v4_q, "input stalled while the pipeline has a bubble")
	`ASSERT_IMPLIES(a_chroma_range, clk, arst_n, m_axis_tvalid,
		m_axis_tdata[39:32] != 8'hFF && m_axis_tdata[47:40] != 8'hFF,
		"chroma reached 255")
	`ASSERT_NEXT(a_empty_u_zero, clk, arst_n, v3_q && ctl.en4 && u_cnt_s3 == '0,
		m_axis_tdata[39:32] == 8'h00, "empty class u gave nonzero chroma")

endmodule

`default_nettype wire

// File: tb/sv/tb_depth_block_to_yuv_pack.sv
module tb_depth_block_to_yuv_pack;
	import dbyp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	// One packed result, top-left luma in the lowest byte.
	typedef struct packed {
		bit [7:0] chroma_v;
		bit [7:0] chroma_u;
		bit [7:0] luma_br;
		bit [7:0] luma_bl;
		bit [7:0] luma_tr;
		bit [7:0] luma_tl;
	} yuv_word_t;

	// Predicts the packed luma and chroma of each accepted block and holds them
	// in order until the matching output transaction arrives.
	class yuv_ledger;
		bit [23:0] scale;
		yuv_word_t awaited[$];
		int unsigned mismatches;

		function new();
			scale = SCALE_RESET;
			mismatches = 0;
		endfunction

		function yuv_word_t pack_block(bit [95:0] depths, bit [3:0] bad);
			bit [47:0] prod;
			bit [7:0] luma;
			bit [31:0] frac;
			bit [7:0] lane_luma [4];
			bit [7:0] first_luma;
			bit have_first;
			bit [63:0] u_sum;
			bit [63:0] v_sum;
			int unsigned u_cnt;
			int unsigned v_cnt;
			yuv_word_t w;
			have_first = 1'b0;
			first_luma = '0;
			u_sum = '0;
			v_sum = '0;
			u_cnt = 0;
			v_cnt = 0;
			for (int k = 0; k < 4; k++) begin
				if (bad[k]) begin
					lane_luma[k] = LUMA_INVALID;
					continue;
				end
				prod = {24'd0, depths[24*k +: 24]} * {24'd0, scale};
				// Integer parts of 255 and up saturate just below 255.
				if (prod[47:32] > 16'(LUMA_MAX)) begin
					luma = LUMA_MAX;
					frac = '1;
				end else begin
					luma = prod[39:32];
					frac = prod[31:0];
				end
				// The first valid lane fixes the luma of class u.
				if (!have_first || luma == first_luma) begin
					have_first = 1'b1;
					first_luma = luma;
					u_sum += frac;
					u_cnt++;
				end else begin
					v_sum += frac;
					v_cnt++;
				end
				lane_luma[k] = luma;
			end
			w.luma_tl = lane_luma[0];
			w.luma_tr = lane_luma[1];
			w.luma_bl = lane_luma[2];
			w.luma_br = lane_luma[3];
			w.chroma_u = (u_cnt == 0) ? 8'd0 : 8'(((u_sum * 255) / u_cnt) >> 32);
			w.chroma_v = (v_cnt == 0) ? 8'd0 : 8'(((v_sum * 255) / v_cnt) >> 32);
			return w;
		endfunction

		function void note_block(bit [95:0] depths, bit [3:0] bad);
			awaited.insert(awaited.size(), pack_block(depths, bad));
		endfunction

		function void check_result(bit [47:0] data);
			yuv_word_t want;
			string names [6];
			names = '{"luma_top_left", "luma_top_right", "luma_bottom_left",
				"luma_bottom_right", "chroma_u", "chroma_v"};
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output transaction: tdata=%h", data);
				return;
			end
			want = awaited.pop_front();
			for (int k = 0; k < 6; k++) begin
				if (want[8*k +: 8] != data[8*k +: 8]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch on %s: expected %0d, got %0d (scale %h)",
							names[k], want[8*k +: 8], data[8*k +: 8], scale);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [23:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic [3:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;

	yuv_ledger ledger;
	bit tx_held;
	bit tx_calm;
	bit rx_calm;
	int unsigned cycles = 0;

	depth_block_to_yuv_pack u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Run watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** depth_block_to_yuv_pack: FAILED **");
			$finish;
		end
	end

	// Result side: check each output transaction, then stall at random.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			ledger.check_result(m_axis_tdata);
		m_axis_tready <= rx_calm || ($urandom_range(99) >= 22);
	end

	// Offers one block and waits for its input transaction; may idle after it.
	task automatic send_block(bit [95:0] depths, bit [3:0] bad);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= depths;
		s_axis_tuser <= bad;
		tx_held = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		ledger.note_block(depths, bad);
		if (!tx_calm && $urandom_range(99) < 22) begin
			s_axis_tvalid <= 1'b0;
			tx_held = 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every predicted result has been checked.
	task automatic settle();
		if (tx_held) begin
			s_axis_tvalid <= 1'b0;
			tx_held = 1'b0;
		end
		@(posedge clk);
		while (ledger.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_scale(bit [23:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ledger.scale = value;
	endtask

	// Random block: mostly lanes clustered around one base so that luma codes
	// repeat and both classes fill; the rest is fully random.
	function automatic void make_block(output bit [95:0] depths, output bit [3:0] bad);
		bit [23:0] base;
		bit [23:0] sample;
		if ($urandom_range(99) < 25) begin
			depths = {$urandom, $urandom, $urandom};
			bad = 4'($urandom);
			return;
		end
		base = 24'($urandom & ((32'd1 << $urandom_range(4, 24)) - 1));
		for (int k = 0; k < 4; k++) begin
			case ($urandom_range(3))
				0: sample = base;
				1: sample = base + 24'($urandom_range(0, 255));
				2: sample = base ^ 24'($urandom & 32'hFFF);
				default: sample = 24'($urandom);
			endcase
			depths[24*k +: 24] = sample;
			bad[k] = ($urandom_range(99) < 12);
		end
	endfunction

	// Hand-picked blocks and random ones, all at the default scale of 31.75.
	task automatic directed_blocks();
		bit [95:0] depths;
		bit [3:0] bad;
		// All zero, all saturated, all invalid.
		send_block('0, 4'b0000);
		send_block({4{24'hFFFFFF}}, 4'b0000);
		send_block({4{24'hFFFFFF}}, 4'b1111);
		// Exact 254, just above 254, and a saturated lane joining class u.
		send_block({24'h000000, 24'h081000, 24'h080001, 24'h080000}, 4'b0000);
		// Leading invalid lane; the next valid lane fixes class u.
		send_block({24'h020000, 24'h010000, 24'h010000, 24'hABCDEF}, 4'b0001);
		// Three lanes in class v.
		send_block({24'h000001, 24'h030000, 24'h020000, 24'h010000}, 4'b0000);
		// Four lanes of one luma in class u.
		send_block({24'h0100C0, 24'h010080, 24'h010040, 24'h010000}, 4'b0000);
		// Every pattern of invalid lanes.
		for (int m = 0; m < 16; m++) begin
			make_block(depths, bad);
			send_block(depths, 4'(m));
		end
	endtask

	initial begin
		bit [95:0] depths;
		bit [3:0] bad;
		bit [23:0] scales [8];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		tx_held = 1'b0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		ledger = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_blocks();

		scales = '{24'hFFFFFF, 24'h000000, 24'h000001, 24'h010000,
			24'($urandom), 24'(SCALE_RESET) ^ 24'($urandom & 32'hFFFF),
			24'($urandom & 32'hFFFFF), SCALE_RESET};
		for (int p = 0; p < 8; p++) begin
			settle();
			write_scale(scales[p]);
			// One phase runs without any idling on either side.
			tx_calm = (p == 3);
			rx_calm = (p == 3);
			for (int n = 0; n < 100; n++) begin
				// Let the pipeline drain completely once mid-phase.
				if (p == 5 && n == 50)
					settle();
				make_block(depths, bad);
				send_block(depths, bad);
			end
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		settle();

		if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
			$display("** depth_block_to_yuv_pack: PASSED **");
		else
			$display("** depth_block_to_yuv_pack: FAILED **");
		$finish;
	end

endmodule
